FILE: hdl/lpdc_pkg.sv
// Package for the lidar point depth colorizer: widths, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package lpdc_pkg;
  localparam int IMG_WIDTH  = 640;
  localparam int IMG_HEIGHT = 480;
  localparam int MAX_RADIUS = 3;
  localparam int NPIX       = IMG_WIDTH * IMG_HEIGHT;
  localparam int PIX_W      = $clog2(NPIX);
  localparam int COL_W      = $clog2(IMG_WIDTH) + 1;
  localparam int ROW_W      = $clog2(IMG_HEIGHT) + 1;

  localparam logic [1:0] KIND_DEPTH = 2'd0;
  localparam logic [1:0] KIND_COLOR = 2'd1;
  localparam logic [1:0] KIND_COEF  = 2'd2;
  localparam logic [1:0] KIND_POINT = 2'd3;

  localparam logic [2:0] ST_KEPT     = 3'd0;
  localparam logic [2:0] ST_BEHIND   = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_EDGE     = 3'd5;
  localparam logic [2:0] ST_MISMATCH = 3'd6;
  localparam logic [2:0] ST_WINDOW   = 3'd7;

  localparam logic [2:0] REG_TOL_BASE  = 3'd0;
  localparam logic [2:0] REG_TOL_SCALE = 3'd1;
  localparam logic [2:0] REG_EDGE      = 3'd2;
  localparam logic [2:0] REG_BORDER    = 3'd3;
  localparam logic [2:0] REG_RADIUS    = 3'd4;
  localparam logic [2:0] REG_MIN_RANGE = 3'd5;
  localparam logic [2:0] REG_MAX_RANGE = 3'd6;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
endpackage

FILE: hdl/lpdc_ram.sv
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lpdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/lpdc_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; used by the top level for the projection.
`timescale 1ns / 1ps
module lpdc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [33:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_r[31:0], q_r[63]};
    trial   = {1'b0, shifted} - {2'b0, d_r};
    if (!trial[33]) begin
      rem_nxt = trial[32:0];
      q_nxt   = {q_r[62:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      q_nxt   = {q_r[62:0], 1'b0};
    end
  end

  // iterate 64 quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
        q_r    <= num[63] ? 64'(-num) : num;
        rem_r  <= '0;
        d_r    <= den[31] ? 32'(-den) : den;
        neg_r  <= num[63] ^ den[31];
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

FILE: hdl/lidar_point_depth_colorizer.sv
// Top level of the lidar point depth colorizer.
// Per point request: the rotation, two divides for the projection, center and neighbor
// depth reads, then a scan of a window of 1 to 49 pixels and a color read; early rejects
// end sooner. Load requests are taken while idle. One request at a time: a new request is
// accepted only after the last result has been handed to the output, which can stall.
// Reset (rst_n, synchronous) restores config registers, state and identity rotation; stores undefined.
// Depends on lpdc_pkg, lpdc_ram and lpdc_div.
`timescale 1ns / 1ps
module lidar_point_depth_colorizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [18:0]        in_pixel_index,
  input  logic [15:0]        in_depth_mm,
  input  logic [23:0]        in_color_bgr,
  input  logic [3:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_out_x,
  output logic signed [31:0] out_out_y,
  output logic signed [31:0] out_out_z,
  output logic [31:0]        out_rgba
);
  localparam int PW = lpdc_pkg::PIX_W;
  localparam int CW = lpdc_pkg::COL_W;
  localparam int RW = lpdc_pkg::ROW_W;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_ACC, S_ZCHK, S_DIVU, S_WAITU, S_DIVV, S_WAITV, S_PIX,
    S_CRD, S_CWT, S_NRD, S_NWT, S_TAU, S_MCHK, S_WRD, S_WCHK, S_COLR, S_COLW,
    S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] tol_base_r, tol_scale_r, edge_r, min_r, max_r;
  logic [8:0]  border_r;
  logic [1:0]  radius_r;
  logic signed [31:0] coef_r [16];

  logic signed [31:0] px_r, py_r, pz_r;
  logic [1:0]  i_r, j_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] cam_r [3];
  logic signed [63:0] zq_r, tau_r, uq_r;
  logic signed [CW:0] uu_r;
  logic signed [RW:0] vv_r;
  logic [15:0] dc_r;
  logic [2:0]  nb_r;
  logic [2:0]  bad_r;
  logic signed [3:0] du_r, dv_r;
  logic        found_r;
  logic signed [63:0] bestd_r;
  logic [PW-1:0] best_a_r;
  logic [2:0]  status_r;
  logic [31:0] rgba_r;

  // memories
  logic [PW-1:0] d_raddr, c_raddr;
  logic [15:0]   d_rdata;
  logic [23:0]   c_rdata;
  logic acc_in;
  logic pix_ok;
  assign acc_in = in_valid && !in_stall;
  assign pix_ok = in_pixel_index < 19'(lpdc_pkg::NPIX);

  lpdc_ram #(.WIDTH(16), .DEPTH(lpdc_pkg::NPIX)) u_depth (
    .clk(clk), .we(acc_in && in_kind == lpdc_pkg::KIND_DEPTH && pix_ok),
    .waddr(in_pixel_index[PW-1:0]), .wdata(in_depth_mm),
    .raddr(d_raddr), .rdata(d_rdata));
  lpdc_ram #(.WIDTH(24), .DEPTH(lpdc_pkg::NPIX)) u_color (
    .clk(clk), .we(acc_in && in_kind == lpdc_pkg::KIND_COLOR && pix_ok),
    .waddr(in_pixel_index[PW-1:0]), .wdata(in_color_bgr),
    .raddr(c_raddr), .rdata(c_rdata));
  assign c_raddr = best_a_r;

  // divider for the projection
  logic div_start, div_done;
  logic signed [63:0] div_num, div_q;
  lpdc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(cam_r[2]), .done(div_done), .quo(div_q));
  assign div_start = (state_r == S_DIVU) || (state_r == S_DIVV);
  assign div_num   = prod_r;

  // pixel address helpers
  function automatic logic [PW-1:0] addr_of(input logic signed [RW:0] r,
                                            input logic signed [CW:0] c);
    logic [PW+RW:0] a;
    a = (PW+RW+1)'(r) * (PW+RW+1)'(lpdc_pkg::IMG_WIDTH) + (PW+RW+1)'(c);
    return a[PW-1:0];
  endfunction

  // neighbour coordinates: right, down, left, up
  logic signed [CW:0] n_c;
  logic signed [RW:0] n_r;
  always_comb begin
    n_c = uu_r;
    n_r = vv_r;
    case (nb_r)
      3'd0: n_c = (uu_r + 1 < (CW+1)'(lpdc_pkg::IMG_WIDTH)) ? uu_r + 1 : uu_r;
      3'd1: n_r = (vv_r + 1 < (RW+1)'(lpdc_pkg::IMG_HEIGHT)) ? vv_r + 1 : vv_r;
      3'd2: n_c = (uu_r > 0) ? uu_r - 1 : uu_r;
      default: n_r = (vv_r > 0) ? vv_r - 1 : vv_r;
    endcase
  end

  logic signed [CW:0] w_c;
  logic signed [RW:0] w_r;
  logic w_in;
  assign w_c  = uu_r + (CW+1)'(du_r);
  assign w_r  = vv_r + (RW+1)'(dv_r);
  assign w_in = w_c >= 0 && w_c < (CW+1)'(lpdc_pkg::IMG_WIDTH) &&
                w_r >= 0 && w_r < (RW+1)'(lpdc_pkg::IMG_HEIGHT);

  always_comb begin
    case (state_r)
      S_CRD:   d_raddr = addr_of(vv_r, uu_r);
      S_NRD:   d_raddr = addr_of(n_r, n_c);
      default: d_raddr = addr_of(w_r, w_c);
    endcase
  end

  // shared values
  logic signed [63:0] dq, dz, accsum, st, rnd_u;
  logic [16:0] nd;
  logic signed [2:0] rad;
  assign dq = {32'd0, d_rdata, 16'd0};
  assign dz = (zq_r > dq) ? zq_r - dq : dq - zq_r;
  assign nd = (d_rdata > dc_r) ? {1'b0, d_rdata} - {1'b0, dc_r}
                               : {1'b0, dc_r} - {1'b0, d_rdata};
  assign accsum = acc_r + (prod_r >>> 30);
  assign st = ($signed({48'd0, tol_scale_r}) * zq_r) >>> 16;
  assign rnd_u = div_q + {{32{uq_r[31]}}, uq_r[31:0]} + 64'sd32768;
  assign rad = $signed({1'b0, radius_r});

  logic signed [63:0] sat_v;
  always_comb begin
    if (accsum > 64'sd2147483647) sat_v = 64'sd2147483647;
    else if (accsum < -64'sd2147483648) sat_v = -64'sd2147483648;
    else sat_v = accsum;
  end

  logic signed [63:0] pix_t;
  assign pix_t = rnd_u[63] ? -((-rnd_u) >>> 16) : (rnd_u >>> 16);

  assign in_stall = state_r != S_IDLE;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_base_r  <= 16'd10050;
      tol_scale_r <= 16'd655;
      edge_r      <= 16'd100;
      border_r    <= 9'd4;
      radius_r    <= 2'd0;
      min_r       <= 16'd300;
      max_r       <= 16'd6000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpdc_pkg::REG_TOL_BASE:  tol_base_r  <= cfg_data;
        lpdc_pkg::REG_TOL_SCALE: tol_scale_r <= cfg_data;
        lpdc_pkg::REG_EDGE:      edge_r      <= cfg_data;
        lpdc_pkg::REG_BORDER:    border_r    <= cfg_data[8:0];
        lpdc_pkg::REG_RADIUS:    radius_r    <= cfg_data[1:0];
        lpdc_pkg::REG_MIN_RANGE: min_r       <= cfg_data;
        lpdc_pkg::REG_MAX_RANGE: max_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // point sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < 16; k++) coef_r[k] <= '0;
      coef_r[0] <= lpdc_pkg::ONE_Q30;
      coef_r[4] <= lpdc_pkg::ONE_Q30;
      coef_r[8] <= lpdc_pkg::ONE_Q30;
    end else begin
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc_in && in_kind == lpdc_pkg::KIND_COEF) coef_r[in_coef_index] <= in_coef_value;
          if (acc_in && in_kind == lpdc_pkg::KIND_POINT) begin
            px_r <= in_point_x; py_r <= in_point_y; pz_r <= in_point_z;
            i_r <= 2'd0; j_r <= 2'd0;
            acc_r <= {{32{coef_r[9][31]}}, coef_r[9]};
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= coef_r[4'(i_r) * 4'd3 + 4'(j_r)] *
                    ((j_r == 2'd0) ? px_r : (j_r == 2'd1) ? py_r : pz_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (j_r == 2'd2) begin
            cam_r[i_r] <= sat_v[31:0];
            j_r <= 2'd0;
            if (i_r == 2'd2) state_r <= S_ZCHK;
            else begin
              i_r <= i_r + 2'd1;
              acc_r <= {{32{coef_r[4'd10 + 4'(i_r)][31]}}, coef_r[4'd10 + 4'(i_r)]};
              state_r <= S_MUL;
            end
          end else begin
            acc_r <= accsum;
            j_r <= j_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_ZCHK: begin
          zq_r <= 64'(cam_r[2]) * 64'sd1000;
          prod_r <= coef_r[12] * cam_r[0];
          uq_r <= 64'(coef_r[14]);
          if (cam_r[2] <= 0) begin
            status_r <= lpdc_pkg::ST_BEHIND; state_r <= S_OUT;
          end else if (64'(cam_r[2]) * 64'sd1000 < $signed({32'd0, min_r, 16'd0}) ||
                       64'(cam_r[2]) * 64'sd1000 > $signed({32'd0, max_r, 16'd0})) begin
            status_r <= lpdc_pkg::ST_RANGE; state_r <= S_OUT;
          end else state_r <= S_DIVU;
        end
        S_DIVU: state_r <= S_WAITU;
        S_WAITU: if (div_done) begin
          if (pix_t < 0 || pix_t >= lpdc_pkg::IMG_WIDTH) begin
            status_r <= lpdc_pkg::ST_OUTSIDE; state_r <= S_OUT;
          end else begin
            uu_r <= pix_t[CW:0];
            prod_r <= coef_r[13] * cam_r[1];
            uq_r <= 64'(coef_r[15]);
            state_r <= S_DIVV;
          end
        end
        S_DIVV: state_r <= S_WAITV;
        S_WAITV: if (div_done) begin
          if (pix_t < 0 || pix_t >= lpdc_pkg::IMG_HEIGHT ||
              pix_t > 64'(lpdc_pkg::IMG_HEIGHT) - $signed(64'(border_r))) begin
            status_r <= lpdc_pkg::ST_OUTSIDE; state_r <= S_OUT;
          end else begin
            vv_r <= pix_t[RW:0];
            state_r <= S_CRD;
          end
        end
        S_PIX: state_r <= S_CRD;
        S_CRD: state_r <= S_CWT;
        S_CWT: begin
          dc_r <= d_rdata;
          nb_r <= 3'd0; bad_r <= 3'd0;
          if (d_rdata == 16'd0) begin
            status_r <= lpdc_pkg::ST_INVALID; state_r <= S_OUT;
          end else state_r <= S_NRD;
        end
        S_NRD: state_r <= S_NWT;
        S_NWT: begin
          if (nd > {1'b0, edge_r}) bad_r <= bad_r + 3'd1;
          if (nb_r == 3'd3) state_r <= S_TAU;
          else begin
            nb_r <= nb_r + 3'd1; state_r <= S_NRD;
          end
        end
        S_TAU: begin
          tau_r <= (st > $signed({32'd0, tol_base_r, 16'd0})) ? st
                   : $signed({32'd0, tol_base_r, 16'd0});
          if (bad_r >= 3'd3) begin
            status_r <= lpdc_pkg::ST_EDGE; state_r <= S_OUT;
          end else state_r <= S_MCHK;
        end
        S_MCHK: begin
          begin : mm
            logic signed [63:0] dcq, dd;
            dcq = {32'd0, dc_r, 16'd0};
            dd = (zq_r > dcq) ? zq_r - dcq : dcq - zq_r;
            if (dd > tau_r) begin
              status_r <= lpdc_pkg::ST_MISMATCH; state_r <= S_OUT;
            end else begin
              du_r <= 4'(-rad); dv_r <= 4'(-rad); found_r <= 1'b0;
              state_r <= S_WRD;
            end
          end
        end
        S_WRD: state_r <= S_WCHK;
        S_WCHK: begin
          if (w_in && d_rdata != 16'd0 && dz <= tau_r && (!found_r || dz < bestd_r)) begin
            found_r <= 1'b1; bestd_r <= dz; best_a_r <= addr_of(w_r, w_c);
          end
          if (du_r == 4'(rad)) begin
            du_r <= 4'(-rad);
            if (dv_r == 4'(rad)) state_r <= S_COLR;
            else begin
              dv_r <= dv_r + 4'sd1; state_r <= S_WRD;
            end
          end else begin
            du_r <= du_r + 4'sd1; state_r <= S_WRD;
          end
        end
        S_COLR: begin
          if (!found_r) begin
            status_r <= lpdc_pkg::ST_WINDOW; state_r <= S_OUT;
          end else state_r <= S_COLW;
        end
        S_COLW: begin
          status_r <= lpdc_pkg::ST_KEPT;
          rgba_r <= {8'hFF, c_rdata};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_status <= status_r;
            out_out_x <= px_r; out_out_y <= py_r; out_out_z <= pz_r;
            out_rgba <= (status_r == lpdc_pkg::ST_KEPT) ? rgba_r : 32'd0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
